// File: hw/rtl/rwlw_pkg.sv
`default_nettype none

package rwlw_pkg;

    // Sizes of the waiter lists and the ids they hold
    localparam int WAITER_SLOTS = 8;
    localparam int ID_BITS      = 16;
    localparam int LOCK_W       = 16;
    localparam int CNT_W        = $clog2(WAITER_SLOTS + 1);
    localparam int ADDR_W       = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;

    // Lock state values
    localparam logic signed [LOCK_W-1:0] READERS_MAX = 16'sd32767;
    localparam logic signed [LOCK_W-1:0] WRITE_HELD  = -16'sd1;
    localparam logic signed [LOCK_W-1:0] LOCK_FREE   = 16'sd0;

    // Opcodes
    localparam logic [1:0] OP_READ_TRY    = 2'd0;
    localparam logic [1:0] OP_READ_UNLOCK = 2'd1;
    localparam logic [1:0] OP_WRITE_TRY   = 2'd2;
    localparam logic [1:0] OP_WRITE_UNLOCK = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_QUEUED   = 3'd1;
    localparam logic [2:0] ST_RETRY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_UNLOCKED = 3'd4;
    localparam logic [2:0] ST_MISUSE   = 3'd5;

    typedef struct packed {
        logic [2:0]               status;
        logic                     wake_valid;
        logic [ID_BITS-1:0]       wake_id;
        logic signed [LOCK_W-1:0] lock_after;
        logic                     last;
    } t_result;

    // One waiter list memory access: write port plus read address
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [ID_BITS-1:0]  wdata;
        logic [ADDR_W-1:0]   raddr;
    } t_ram_req;

endpackage

`default_nettype wire

// File: hw/rtl/rwlw_ram.sv
`default_nettype none

module rwlw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/rwlw_ctrl.sv
`default_nettype none

module rwlw_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [rwlw_pkg::ID_BITS-1:0]  i_waiter_id,
    input  wire logic                          i_can_park,
    input  wire logic                          i_out_free,
    output logic                               o_res_valid,
    output rwlw_pkg::t_result                  o_res,
    output rwlw_pkg::t_ram_req                 o_rd_req,
    output rwlw_pkg::t_ram_req                 o_wr_req,
    input  wire logic [rwlw_pkg::ID_BITS-1:0]  i_rd_rdata,
    input  wire logic [rwlw_pkg::ID_BITS-1:0]  i_wr_rdata
);

    import rwlw_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                     r_state, n_state;
    logic signed [LOCK_W-1:0] r_lock, n_lock;
    logic [CNT_W-1:0]         r_rcnt, n_rcnt;
    logic [CNT_W-1:0]         r_wcnt, n_wcnt;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic [1:0]               r_op;
    logic [ID_BITS-1:0]       r_id;
    logic                     r_park;

    logic                     can_wait;
    logic [CNT_W-1:0]         w_dec;
    logic [CNT_W-1:0]         idx_inc;
    logic                     rd_we, wr_we;

    assign o_in_stall = (r_state != S_IDLE);
    assign can_wait   = (r_id != '0) && r_park;
    assign w_dec      = r_wcnt - CNT_W'(1);
    assign idx_inc    = r_idx + CNT_W'(1);

    // Decide the result of the held request and the next state
    always_comb begin
        n_state  = r_state;
        n_lock   = r_lock;
        n_rcnt   = r_rcnt;
        n_wcnt   = r_wcnt;
        n_idx    = (r_state == S_IDLE) ? '0 : r_idx;
        rd_we    = 1'b0;
        wr_we    = 1'b0;
        o_res_valid       = 1'b0;
        o_res.status      = ST_UNLOCKED;
        o_res.wake_valid  = 1'b0;
        o_res.wake_id     = '0;
        o_res.last        = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                    case (r_op)
                        OP_READ_TRY: begin
                            if (r_lock >= 0 && r_lock != READERS_MAX) begin
                                n_lock       = r_lock + 16'sd1;
                                o_res.status = ST_GRANTED;
                            end else if (r_lock >= 0 || !can_wait) begin
                                o_res.status = ST_RETRY;
                            end else if (r_rcnt >= CNT_W'(WAITER_SLOTS)) begin
                                o_res.status = ST_FULL;
                            end else begin
                                rd_we        = 1'b1;
                                n_rcnt       = r_rcnt + CNT_W'(1);
                                o_res.status = ST_QUEUED;
                            end
                        end
                        OP_READ_UNLOCK: begin
                            if (r_lock <= 0) begin
                                o_res.status = ST_MISUSE;
                            end else begin
                                n_lock = r_lock - 16'sd1;
                                // last reader out wakes the newest writer
                                if (r_lock == 16'sd1 && r_wcnt != '0) begin
                                    n_wcnt           = w_dec;
                                    o_res.wake_valid = 1'b1;
                                    o_res.wake_id    = i_wr_rdata;
                                end
                            end
                        end
                        OP_WRITE_TRY: begin
                            if (r_lock == LOCK_FREE) begin
                                n_lock       = WRITE_HELD;
                                o_res.status = ST_GRANTED;
                            end else if (!can_wait) begin
                                o_res.status = ST_RETRY;
                            end else if (r_wcnt >= CNT_W'(WAITER_SLOTS)) begin
                                o_res.status = ST_FULL;
                            end else begin
                                wr_we        = 1'b1;
                                n_wcnt       = r_wcnt + CNT_W'(1);
                                o_res.status = ST_QUEUED;
                            end
                        end
                        default: begin
                            // write unlock: free, then wake readers in order, else the newest writer
                            n_lock = LOCK_FREE;
                            if (r_rcnt != '0) begin
                                o_res.wake_valid = 1'b1;
                                o_res.wake_id    = i_rd_rdata;
                                o_res.last       = (idx_inc == r_rcnt);
                                if (idx_inc == r_rcnt) begin
                                    n_rcnt = '0;
                                end else begin
                                    n_idx   = idx_inc;
                                    n_state = S_EXEC;
                                end
                            end else if (r_wcnt != '0) begin
                                n_wcnt           = w_dec;
                                o_res.wake_valid = 1'b1;
                                o_res.wake_id    = i_wr_rdata;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_res.lock_after = n_lock;
    end

    // Reader list: append at the count, sweep from the head
    assign o_rd_req.we    = rd_we;
    assign o_rd_req.waddr = r_rcnt[ADDR_W-1:0];
    assign o_rd_req.wdata = r_id;
    assign o_rd_req.raddr = n_idx[ADDR_W-1:0];

    // Writer list: push at the count, pop the newest
    assign o_wr_req.we    = wr_we;
    assign o_wr_req.waddr = r_wcnt[ADDR_W-1:0];
    assign o_wr_req.wdata = r_id;
    assign o_wr_req.raddr = (r_wcnt == '0) ? '0 : w_dec[ADDR_W-1:0];

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lock  <= LOCK_FREE;
            r_rcnt  <= '0;
            r_wcnt  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_lock  <= n_lock;
            r_rcnt  <= n_rcnt;
            r_wcnt  <= n_wcnt;
            r_idx   <= n_idx;
        end
    end

    // Request capture on transfer
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op   <= i_opcode;
            r_id   <= i_waiter_id;
            r_park <= i_can_park;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rwlw_outreg.sv
`default_nettype none

module rwlw_outreg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_load,
    input  wire rwlw_pkg::t_result                   i_res,
    output logic                                     o_free,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [2:0]                               o_status,
    output logic                                     o_wake_valid,
    output logic [rwlw_pkg::ID_BITS-1:0]             o_wake_id,
    output logic signed [rwlw_pkg::LOCK_W-1:0]       o_lock_state_after,
    output logic                                     o_last
);

    import rwlw_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Slot is free when empty or being drained this cycle
    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid        = r_valid;
    assign o_status           = r_res.status;
    assign o_wake_valid       = r_res.wake_valid;
    assign o_wake_id          = r_res.wake_id;
    assign o_lock_state_after = r_res.lock_after;
    assign o_last             = r_res.last;

endmodule

`default_nettype wire

// File: hw/rtl/reader_writer_lock_waiters_top.sv
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall  i_opcode, i_waiter_id, i_can_park
// out       output     o_out_valid / i_out_stall o_status, o_wake_valid, o_wake_id,
//                                               o_lock_state_after, o_last
//
// A request is captured in the idle state, which addresses the waiter list RAMs;
// the exec state acts on the registered read data. A write unlock with N queued
// readers wakes one per cycle from the reader list RAM while the output register
// is free. Reset clears the lock to free and both list counts to zero; no
// clearing pass. A stalled output holds its result; processing waits while the
// output register stays full, and new requests are stalled until the last result.
`default_nettype none

module reader_writer_lock_waiters_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [1:0]                          i_opcode,
    input  wire logic [rwlw_pkg::ID_BITS-1:0]        i_waiter_id,
    input  wire logic                                i_can_park,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [2:0]                               o_status,
    output logic                                     o_wake_valid,
    output logic [rwlw_pkg::ID_BITS-1:0]             o_wake_id,
    output logic signed [rwlw_pkg::LOCK_W-1:0]       o_lock_state_after,
    output logic                                     o_last
);

    import rwlw_pkg::*;

    logic               out_free;
    logic               res_valid;
    t_result            res;
    t_ram_req           rd_req;
    t_ram_req           wr_req;
    logic [ID_BITS-1:0] rd_rdata;
    logic [ID_BITS-1:0] wr_rdata;

    // Lock sequencer
    rwlw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_waiter_id (i_waiter_id),
        .i_can_park  (i_can_park),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_rd_req    (rd_req),
        .o_wr_req    (wr_req),
        .i_rd_rdata  (rd_rdata),
        .i_wr_rdata  (wr_rdata)
    );

    // Reader waiter list
    rwlw_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (WAITER_SLOTS)
    ) u_rd_list (
        .i_clk   (i_clk),
        .i_we    (rd_req.we),
        .i_waddr (rd_req.waddr),
        .i_wdata (rd_req.wdata),
        .i_raddr (rd_req.raddr),
        .o_rdata (rd_rdata)
    );

    // Writer waiter list
    rwlw_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (WAITER_SLOTS)
    ) u_wr_list (
        .i_clk   (i_clk),
        .i_we    (wr_req.we),
        .i_waddr (wr_req.waddr),
        .i_wdata (wr_req.wdata),
        .i_raddr (wr_req.raddr),
        .o_rdata (wr_rdata)
    );

    // Result register
    rwlw_outreg u_outreg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (res_valid),
        .i_res              (res),
        .o_free             (out_free),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_wake_valid       (o_wake_valid),
        .o_wake_id          (o_wake_id),
        .o_lock_state_after (o_lock_state_after),
        .o_last             (o_last)
    );

`ifndef SYNTHESIS
    // An accepted request blocks the input until its work is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after request transfer");

    // Misuse, refusals and queued requests never wake anyone
    a_no_wake_on_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_MISUSE || o_status == ST_RETRY ||
                         o_status == ST_FULL || o_status == ST_QUEUED))
        |-> !o_wake_valid)
        else $error("wake on refused request");

    // A grant leaves the lock held
    a_grant_holds_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_GRANTED) |-> (o_lock_state_after != LOCK_FREE))
        else $error("grant left lock free");

    // Every wake result leaves the lock non-writer
    a_wake_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_wake_valid) |->
        (o_status == ST_UNLOCKED && o_lock_state_after == LOCK_FREE))
        else $error("wake with lock still held");
`endif

endmodule

`default_nettype wire
